>>> rtl/ibm_pkg.sv
// Shared types, codes and default sizes for the inode bitmap allocator.
`timescale 1ns / 1ps

package ibm_pkg;

	localparam int unsigned FIELD_W         = 14;
	localparam int unsigned MAP_BITS_DEF    = 8192;
	localparam int unsigned WORD_BITS_DEF   = 32;
	localparam int unsigned NUM_ENTRIES_RST = 8192;

	typedef logic [FIELD_W-1:0] field_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_ALREADY = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t  mode;
		field_t number;
	} req_t;

	typedef struct packed {
		status_t status;
		field_t  number_out;
		field_t  free_count;
	} rsp_t;

endpackage

>>> rtl/inode_bitmap_allocator.sv
// Top level of the first-fit inode bitmap allocator with its map memory and sequencer.
`timescale 1ns / 1ps

// First-fit bitmap allocator. An allocate item scans the usage map one word per
// cycle from entry 0 and marks the lowest free entry below the effective count,
// min(num_entries, MAP_BITS, 16383); it returns that entry's one-based number, or status
// full with number 0. A free item clears the entry given by its one-based number;
// number 0 or a number above the count is rejected as out of range, and freeing an
// entry that is already free returns status already-free and changes nothing.
// Every result carries the number of entries still free, saturated at zero. After
// reset the block runs a clearing pass over all MAP_WORDS words (256 by default), during
// which it takes no item; configuration writes are accepted at any time but are
// meant to be made while the block is idle. The single map read port sets the
// rate: an allocate item reads map words until it finds a free entry or passes the
// count, and a free item reads only the word of its entry. One item is in work at a
// time, while the output register may still hold the previous result. WORD_BITS
// must be a power of two.
module inode_bitmap_allocator #(
	parameter int unsigned MAP_BITS  = ibm_pkg::MAP_BITS_DEF,
	parameter int unsigned WORD_BITS = ibm_pkg::WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    num_entries_we,
	input  ibm_pkg::field_t         num_entries_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ibm_pkg::req_t           in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ibm_pkg::rsp_t           out_data
);
	import ibm_pkg::*;

	localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BIT_W     = $clog2(WORD_BITS);
	localparam int unsigned BASE_W    = FIELD_W + 1;
	localparam int unsigned MAP_CAP   = (MAP_BITS < (1 << FIELD_W)) ? MAP_BITS
	                                                                : (1 << FIELD_W) - 1;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FREAD = 6'b001000,
		S_FEVAL = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                state_q;
	field_t                num_entries_q;
	field_t                lim_q;
	field_t                used_q;
	logic [WADDR_W-1:0]    waddr_q;
	logic [WADDR_W-1:0]    eaddr_q;
	logic [BASE_W-1:0]     issue_base_q;
	logic [BASE_W-1:0]     ebase_q;
	logic                  evalid_q;
	logic [BIT_W-1:0]      fpos_q;
	field_t                fnum_q;
	status_t               res_status_q;
	field_t                res_num_q;
	logic                  out_valid_q;
	rsp_t                  out_data_q;

	logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0]  rd_data_q;
	logic                  wr_en;
	logic [WADDR_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0]  wr_data;

	field_t                lim_c;
	field_t                fbit_c;
	field_t                free_c;
	logic                  issuing;
	logic [BASE_W-1:0]     rem_c;
	logic                  scan_found;
	logic [BIT_W-1:0]      scan_idx;
	logic [WORD_BITS-1:0]  scan_word;
	logic                  fbit_set;
	logic                  out_free;

	// Effective entry count: the configured count, capped at the map size and at 16383.
	assign lim_c   = (num_entries_q > FIELD_W'(MAP_CAP)) ? FIELD_W'(MAP_CAP) : num_entries_q;
	assign fbit_c  = in_data.number - FIELD_W'(1);
	assign free_c  = (lim_q > used_q) ? (lim_q - used_q) : '0;

	// A word is read only while its first entry lies below the count.
	assign issuing = (issue_base_q < {1'b0, lim_q});
	assign rem_c   = {1'b0, lim_q} - ebase_q;

	assign fbit_set = rd_data_q[fpos_q];
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ibm_scan_unit #(
		.WORD_BITS (WORD_BITS)
	) u_scan (
		.word     (rd_data_q),
		.rem      (rem_c),
		.found    (scan_found),
		.idx      (scan_idx),
		.word_set (scan_word)
	);

	// Map memory: one write port, one registered read port addressed by waddr_q.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= map_mem[waddr_q];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = waddr_q;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				wr_en   = evalid_q && scan_found;
				wr_addr = eaddr_q;
				wr_data = scan_word;
			end
			S_FEVAL: begin
				wr_en   = fbit_set;
				wr_data = rd_data_q & ~(WORD_BITS'(1) << fpos_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= FIELD_W'(NUM_ENTRIES_RST);
		end else if (num_entries_we) begin
			num_entries_q <= num_entries_wdata;
		end
	end

	// Sequencer. The scan overlaps the read of the next word with the evaluation
	// of the current one; a word read after the hit is simply dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			waddr_q      <= '0;
			eaddr_q      <= '0;
			issue_base_q <= '0;
			ebase_q      <= '0;
			evalid_q     <= 1'b0;
			lim_q        <= '0;
			used_q       <= '0;
			fpos_q       <= '0;
			fnum_q       <= '0;
			res_status_q <= ST_OK;
			res_num_q    <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			// A taken result empties the output register unless the done state
			// loads the next one in the same cycle.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (waddr_q == WADDR_W'(MAP_WORDS - 1)) begin
						waddr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						waddr_q <= waddr_q + WADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						lim_q     <= lim_c;
						res_num_q <= '0;
						if (in_data.mode == MODE_ALLOC) begin
							if (lim_c == '0) begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								waddr_q      <= '0;
								issue_base_q <= '0;
								evalid_q     <= 1'b0;
								state_q      <= S_SCAN;
							end
						end else if (in_data.number == '0 || in_data.number > lim_c) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							waddr_q <= WADDR_W'(fbit_c >> BIT_W);
							fpos_q  <= fbit_c[BIT_W-1:0];
							fnum_q  <= in_data.number;
							state_q <= S_FREAD;
						end
					end
				end
				S_SCAN: begin
					evalid_q <= issuing;
					ebase_q  <= issue_base_q;
					eaddr_q  <= waddr_q;
					if (issuing) begin
						waddr_q      <= waddr_q + WADDR_W'(1);
						issue_base_q <= issue_base_q + BASE_W'(WORD_BITS);
					end
					if (evalid_q && scan_found) begin
						used_q       <= used_q + FIELD_W'(1);
						res_status_q <= ST_OK;
						res_num_q    <= FIELD_W'(ebase_q + BASE_W'(scan_idx) + BASE_W'(1));
						evalid_q     <= 1'b0;
						state_q      <= S_DONE;
					end else if (!issuing) begin
						res_status_q <= ST_FULL;
						evalid_q     <= 1'b0;
						state_q      <= S_DONE;
					end
				end
				S_FREAD: begin
					state_q <= S_FEVAL;
				end
				S_FEVAL: begin
					if (fbit_set) begin
						if (used_q != '0) begin
							used_q <= used_q - FIELD_W'(1);
						end
						res_status_q <= ST_OK;
						res_num_q    <= fnum_q;
					end else begin
						res_status_q <= ST_ALREADY;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q.status     <= res_status_q;
						out_data_q.number_out <= res_num_q;
						out_data_q.free_count <= free_c;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/ibm_scan_unit.sv
// Word evaluator of the scan: finds the lowest free bit of one map word below a limit.
`timescale 1ns / 1ps

module ibm_scan_unit #(
	parameter int unsigned WORD_BITS = ibm_pkg::WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0]                     word,
	input  logic [ibm_pkg::FIELD_W:0]                rem,
	output logic                                     found,
	output logic [$clog2(WORD_BITS)-1:0]             idx,
	output logic [WORD_BITS-1:0]                     word_set
);
	import ibm_pkg::*;

	localparam int unsigned BIT_W  = $clog2(WORD_BITS);
	localparam int unsigned BASE_W = FIELD_W + 1;

	logic [WORD_BITS-1:0] in_range;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] low;

	// Bits at or above the entry limit count as used.
	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			in_range[k] = (rem > BASE_W'(k));
		end
	end

	assign cand     = ~word & in_range;
	assign low      = cand & (~cand + WORD_BITS'(1));
	assign found    = |cand;
	assign word_set = word | low;

	// The isolated bit is one-hot, so an OR of the positions encodes it.
	always_comb begin
		idx = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			if (low[k]) begin
				idx = idx | BIT_W'(k);
			end
		end
	end

endmodule

>>> bench/inode_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit inode bitmap allocator.
`timescale 1ns / 1ps

// The bench runs in two parts. First comes a short table of hand-picked items:
// allocate right after reset, the number field at zero, one past the count and all
// ones, a double free, a zero entry count, a count shrunk below the entries in use,
// and a count of one that fills up at once. The expected results in the table are
// typed in where they are obvious; the other rows use the predictor. Then comes a
// series of random phases. Each phase has its own entry count and handshake
// pattern. Most items are well formed: they allocate, or they free an entry that
// is known to be in use. The rest are noise: double frees, numbers out of range,
// and random fields. Every accepted result is compared with the oldest expected
// result, field by field.
module inode_bitmap_allocator_tb;

	import ibm_pkg::*;

	typedef enum bit [1:0] {
		ROW_CFG,   // write num_entries with the number column
		ROW_PRED,  // item checked against the predictor
		ROW_TYPED  // item checked against the result typed into the row
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		mode_t     mode;
		field_t    number;
		rsp_t      want;
	} plan_row_t;

	typedef enum bit [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		field_t      entries;
		int unsigned n_items;
		idle_mode_t  idle;
	} phase_t;

	localparam rsp_t NO_RSP = '{ST_OK, 14'd0, 14'd0};

	// Directed part. The rows run in order. A config row first waits until the block
	// has gone idle.
	plan_row_t plan [0:28] = '{
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_OK,      14'd1, 14'd8191}},
		'{ROW_TYPED, MODE_ALLOC, 14'd16383, '{ST_OK,      14'd2, 14'd8190}},
		'{ROW_TYPED, MODE_FREE,  14'd0,     '{ST_RANGE,   14'd0, 14'd8190}},
		'{ROW_TYPED, MODE_FREE,  14'd8193,  '{ST_RANGE,   14'd0, 14'd8190}},
		'{ROW_TYPED, MODE_FREE,  14'd16383, '{ST_RANGE,   14'd0, 14'd8190}},
		'{ROW_TYPED, MODE_FREE,  14'd8192,  '{ST_ALREADY, 14'd0, 14'd8190}},
		'{ROW_TYPED, MODE_FREE,  14'd2,     '{ST_OK,      14'd2, 14'd8191}},
		'{ROW_TYPED, MODE_FREE,  14'd2,     '{ST_ALREADY, 14'd0, 14'd8191}},
		'{ROW_PRED,  MODE_ALLOC, 14'd0,     NO_RSP},
		'{ROW_PRED,  MODE_ALLOC, 14'd0,     NO_RSP},
		'{ROW_CFG,   MODE_ALLOC, 14'd0,     NO_RSP},
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_FULL,    14'd0, 14'd0}},
		'{ROW_TYPED, MODE_FREE,  14'd1,     '{ST_RANGE,   14'd0, 14'd0}},
		'{ROW_CFG,   MODE_ALLOC, 14'd2,     NO_RSP},
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_FULL,    14'd0, 14'd0}},
		'{ROW_TYPED, MODE_FREE,  14'd3,     '{ST_RANGE,   14'd0, 14'd0}},
		'{ROW_PRED,  MODE_FREE,  14'd2,     NO_RSP},
		'{ROW_PRED,  MODE_FREE,  14'd1,     NO_RSP},
		'{ROW_PRED,  MODE_ALLOC, 14'd0,     NO_RSP},
		'{ROW_PRED,  MODE_ALLOC, 14'd0,     NO_RSP},
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_FULL,    14'd0, 14'd0}},
		'{ROW_CFG,   MODE_ALLOC, 14'd16383, NO_RSP},
		'{ROW_PRED,  MODE_FREE,  14'd3,     NO_RSP},
		'{ROW_PRED,  MODE_FREE,  14'd1,     NO_RSP},
		'{ROW_PRED,  MODE_FREE,  14'd2,     NO_RSP},
		'{ROW_CFG,   MODE_ALLOC, 14'd1,     NO_RSP},
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_OK,      14'd1, 14'd0}},
		'{ROW_TYPED, MODE_ALLOC, 14'd0,     '{ST_FULL,    14'd0, 14'd0}},
		'{ROW_PRED,  MODE_FREE,  14'd1,     NO_RSP}
	};

	// Random phases. Small counts make the map fill up, so the full status comes
	// often. Large counts keep scans short, because only the first few hundred
	// entries are ever used.
	phase_t phases [0:8] = '{
		'{14'd8192,  260, IDLE_NONE},
		'{14'd40,    260, IDLE_SEND},
		'{14'd1,     100, IDLE_RECV},
		'{14'd300,   260, IDLE_BOTH},
		'{14'd17,    240, IDLE_NONE},
		'{14'd0,      40, IDLE_RECV},
		'{14'd16383, 200, IDLE_SEND},
		'{14'd100,   200, IDLE_BOTH},
		'{14'd8192,  140, IDLE_RECV}
	};

	logic   clk = 1'b0;
	logic   arst_n;
	logic   num_entries_we;
	field_t num_entries_wdata;
	logic   in_valid;
	logic   in_ready;
	req_t   in_data;
	logic   out_valid;
	logic   out_ready;
	rsp_t   out_data;

	// The predictor's copy of the block state: the occupancy of each entry, the
	// number of entries in use, and the entry count register.
	bit          occupied [MAP_BITS_DEF];
	int unsigned in_use;
	field_t      entries_reg;

	rsp_t        rsp_due [$];   // results still to come, oldest first
	int unsigned held [$];      // one-based numbers that are allocated now
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          valid_up = 1'b0;  // the level last put on in_valid

	inode_bitmap_allocator DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.num_entries_we    (num_entries_we),
		.num_entries_wdata (num_entries_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_data           (in_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The effective count: a register value above the map size is clipped to it.
	function automatic int unsigned entry_span();
		return (entries_reg < MAP_BITS_DEF) ? entries_reg : MAP_BITS_DEF;
	endfunction

	// First-fit step. An allocate request takes the lowest clear entry below the
	// count. A free request clears the given entry. The free count saturates at
	// zero, because entries above a shrunk count stay in use.
	function automatic rsp_t first_fit_step(req_t r);
		int unsigned span;
		rsp_t        res;
		span = entry_span();
		res = NO_RSP;
		if (r.mode == MODE_ALLOC) begin
			res.status = ST_FULL;
			for (int unsigned i = 0; i < span; i++) begin
				if (!occupied[i]) begin
					occupied[i] = 1'b1;
					in_use++;
					res.status = ST_OK;
					res.number_out = field_t'(i + 1);
					break;
				end
			end
		end else if (r.number == 0 || r.number > span) begin
			res.status = ST_RANGE;
		end else if (!occupied[r.number - 1]) begin
			res.status = ST_ALREADY;
		end else begin
			occupied[r.number - 1] = 1'b0;
			if (in_use > 0)
				in_use--;
			res.number_out = r.number;
		end
		res.free_count = field_t'((span > in_use) ? span - in_use : 0);
		return res;
	endfunction

	// Predicts one item, keeps the list of allocated numbers up to date, then
	// presents the item after an optional random gap and holds it until it is
	// accepted.
	task automatic issue(req_t r, bit typed, rsp_t want);
		rsp_t pred;
		pred = first_fit_step(r);
		rsp_due.push_back(typed ? want : pred);
		if (pred.status == ST_OK && r.mode == MODE_ALLOC) begin
			held.push_back(pred.number_out);
		end else if (pred.status == ST_OK) begin
			for (int k = 0; k < held.size(); k++) begin
				if (held[k] == r.number) begin
					held.delete(k);
					break;
				end
			end
		end
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			if (valid_up) begin
				in_valid <= 1'b0;
				valid_up = 1'b0;
			end
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= r;
		valid_up = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Lowers valid and waits until every expected result has come back. The loop
	// waits on the clock before it tests the queue, so valid is never lowered and raised in one step.
	task automatic drain();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		do @(posedge clk); while (rsp_due.size() != 0);
	endtask

	// Every item has a result, so once the queue is empty the block is idle. A
	// further wait on the clock lets the output register settle before the write.
	task automatic write_entries(field_t value);
		drain();
		repeat (4) @(posedge clk);
		num_entries_we <= 1'b1;
		num_entries_wdata <= value;
		@(posedge clk);
		num_entries_we <= 1'b0;
		num_entries_wdata <= field_t'($urandom_range(16383));
		entries_reg = value;
	endtask

	// Accepted results are compared with the oldest expected result. The ready
	// level for the next edge is chosen here, from the stall rate of the phase.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (out_valid && out_ready) begin
			if (rsp_due.size() == 0) begin
				$error("result with nothing expected: status %0d number_out %0d free_count %0d",
					out_data.status, out_data.number_out, out_data.free_count);
				errors++;
			end else begin
				want = rsp_due.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					errors++;
				end
				if (out_data.number_out !== want.number_out) begin
					$error("number_out: expected %0d, got %0d", want.number_out,
						out_data.number_out);
					errors++;
				end
				if (out_data.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d", want.free_count,
						out_data.free_count);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The slowest correct run is about 1750 items, each of which may scan the whole map,
	// plus gaps and stalls and the clearing pass after reset. That is well under
	// ten milliseconds, so twenty is generous.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		req_t        r;
		int unsigned span;
		int unsigned pick;
		arst_n <= 1'b0;
		num_entries_we <= 1'b0;
		num_entries_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		for (int i = 0; i < MAP_BITS_DEF; i++)
			occupied[i] = 1'b0;
		in_use = 0;
		entries_reg = field_t'(NUM_ENTRIES_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows. The block clears its map after reset; the first item
		// simply waits for in_ready.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_entries(plan[i].number);
			end else begin
				r.mode = plan[i].mode;
				r.number = plan[i].number;
				issue(r, plan[i].kind == ROW_TYPED, plan[i].want);
			end
		end

		// Random phases.
		foreach (phases[p]) begin
			write_entries(phases[p].entries);
			case (phases[p].idle)
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SEND: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
				end
				IDLE_RECV: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			for (int unsigned n = 0; n < phases[p].n_items; n++) begin
				// Halfway through each phase, and now and then at random, the
				// sender stops until every expected result has come back.
				if (n == phases[p].n_items / 2 || $urandom_range(99) == 0)
					drain();
				span = entry_span();
				pick = $urandom_range(99);
				if (pick < 48) begin
					// Allocate. The number field is ignored, so it gets random bits.
					r.mode = MODE_ALLOC;
					r.number = field_t'($urandom_range(16383));
				end else if (pick < 82 && held.size() > 0) begin
					r.mode = MODE_FREE;
					r.number = field_t'(held[$urandom_range(held.size() - 1)]);
				end else begin
					// Noise: double frees and edge numbers near the count, or any
					// number the field can hold.
					r.mode = mode_t'($urandom_range(1));
					if ($urandom_range(1))
						r.number = field_t'($urandom_range(span + 1));
					else
						r.number = field_t'($urandom_range(16383));
				end
				issue(r, 1'b0, NO_RSP);
			end
		end

		// Wait for the last results, then wait long enough for a full scan, so that the
		// block can show any result that should not be there.
		drain();
		recv_stall_pct = 0;
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
